// ===== hw/rtl/rxyz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxyz_pkg
// Shared types and constants for the Euler angle extraction block.
// ----------------------------------------------------------------------------
package rxyz_pkg;

	localparam int CW = 40;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [33:0] zval_t;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = 34'sd1 <<< (30 - i);
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [15:0] m02;
		logic signed [15:0] rr;
		logic signed [15:0] rp;
		logic signed [15:0] ry;
		logic [13:0]        win;
	} side_t;

endpackage

// ===== hw/rtl/rotation_to_xyz_euler_unwrap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_to_xyz_euler_unwrap_core
// Rotation matrix to X-Y-Z Euler angles with solution choice and unwrapping.
// Root: 32 stages. Throughput: one item per cycle; the pipeline halts only
// when the result queue holds three entries, a result waits at its input and
// no pop comes. Reset clears the pipeline and the queue, window reads 6431.
// ----------------------------------------------------------------------------
module rotation_to_xyz_euler_unwrap_core import rxyz_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 12,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] m00,
	input  logic signed [15:0] m01,
	input  logic signed [15:0] m02,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m22,
	input  logic signed [15:0] ref_roll,
	input  logic signed [15:0] ref_pitch,
	input  logic signed [15:0] ref_yaw,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll_out,
	output logic signed [15:0] pitch_out,
	output logic signed [15:0] yaw_out,
	output logic               second_solution,
	output logic               no_pitch_match
);
	localparam int QD = 4;

	logic [13:0] win_q;
	logic en, fv;
	logic signed [ANGLE_FRAC_BITS+5:0] x0, x1, z0, z1, y0;
	side_t si, so;
	logic [49:0] res;
	logic [49:0] mem_q [QD];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) win_q <= 14'd6431;
		else if (cfg_valid) win_q <= cfg_data;
	end

	// The pipeline advances when the queue holds fewer than three results, a pop frees one, or no valid result waits.
	assign en   = (cnt_q < 3'(QD - 1)) || (pop && !empty) || !fv;
	assign full = !en;
	assign si   = '{m02: m02, rr: ref_roll, rp: ref_pitch, ry: ref_yaw, win: win_q};

	rxyz_front #(.STEPS(CORDIC_STEPS), .AFB(ANGLE_FRAC_BITS)) u_front (
		.clk, .arst_n, .en, .in_v(push && en), .m00, .m01, .m12, .m22,
		.side_in(si), .out_v(fv), .x0, .x1, .z0, .z1, .y0, .side_out(so)
	);
	rxyz_back #(.AFB(ANGLE_FRAC_BITS)) u_back (
		.x0, .x1, .z0, .z1, .y0, .side(so), .res
	);

	logic wr, rd;
	assign wr = fv && en;
	assign rd = pop && !empty;
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= res;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

	assign empty = (cnt_q == '0);
	assign {roll_out, pitch_out, yaw_out, second_solution, no_pitch_match} = mem_q[rp_q];

endmodule

// ===== hw/rtl/rxyz_atan2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxyz_atan2
// Pipelined vectoring CORDIC atan2, one stage per iteration.
// ----------------------------------------------------------------------------
module rxyz_atan2 import rxyz_pkg::*; #(
	parameter int STEPS = 16,
	parameter int AFB   = 12
) (
	input  logic                  clk,
	input  logic                  en,
	input  cval_t                 y,
	input  cval_t                 x,
	output logic signed [AFB+5:0] ang
);
	localparam int SH = 30 - AFB;
	typedef logic signed [AFB+5:0] ang_t;

	cval_t xs_q [STEPS+1];
	cval_t ys_q [STEPS+1];
	zval_t zs_q [STEPS+1];
	logic  zr_q [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zr_q[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				zs_q[0] <= (y >= 0) ? zval_t'(PI_Q30) : -zval_t'(PI_Q30);
				xs_q[0] <= -x;
				ys_q[0] <= -y;
			end else begin
				zs_q[0] <= '0;
				xs_q[0] <= x;
				ys_q[0] <= y;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				zr_q[i+1] <= zr_q[i];
				if (ys_q[i] >= 0) begin
					xs_q[i+1] <= xs_q[i] + (ys_q[i] >>> i);
					ys_q[i+1] <= ys_q[i] - (xs_q[i] >>> i);
					zs_q[i+1] <= zs_q[i] + atan_q30(i);
				end else begin
					xs_q[i+1] <= xs_q[i] - (ys_q[i] >>> i);
					ys_q[i+1] <= ys_q[i] + (xs_q[i] >>> i);
					zs_q[i+1] <= zs_q[i] - atan_q30(i);
				end
			end
		end
	end

	zval_t zrnd;
	assign zrnd = zs_q[STEPS] + (zval_t'(1) <<< (SH - 1));
	assign ang  = zr_q[STEPS] ? '0 : ang_t'(zrnd >>> SH);

endmodule

// ===== hw/rtl/rxyz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxyz_front
// Square root and five atan2 units.
// ----------------------------------------------------------------------------
module rxyz_front import rxyz_pkg::*; #(
	parameter int STEPS = 16,
	parameter int AFB   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic signed [15:0]    m00,
	input  logic signed [15:0]    m01,
	input  logic signed [15:0]    m12,
	input  logic signed [15:0]    m22,
	input  side_t                 side_in,
	output logic                  out_v,
	output logic signed [AFB+5:0] x0,
	output logic signed [AFB+5:0] x1,
	output logic signed [AFB+5:0] z0,
	output logic signed [AFB+5:0] z1,
	output logic signed [AFB+5:0] y0,
	output side_t                 side_out
);
	// Stage 1 forms the squares, then 32 restoring root steps, one per stage.
	localparam int RS = 32;
	localparam int LAT = 1 + RS + 1 + STEPS;

	logic [31:0]  sq_s1;
	logic signed [15:0] a_q [LAT+1];
	logic signed [15:0] b_q [LAT+1];
	logic signed [15:0] c_q [LAT+1];
	logic signed [15:0] d_q [LAT+1];
	side_t sd_q [LAT+1];
	logic  vv_q [LAT+1];

	logic [63:0] rn_q [RS+1];
	logic [63:0] rr_q [RS+1];

	assign a_q[0] = m00; assign b_q[0] = m01; assign c_q[0] = m12; assign d_q[0] = m22;
	assign sd_q[0] = side_in; assign vv_q[0] = in_v;

	for (genvar k = 0; k < LAT; k++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				a_q[k+1] <= a_q[k]; b_q[k+1] <= b_q[k];
				c_q[k+1] <= c_q[k]; d_q[k+1] <= d_q[k];
				sd_q[k+1] <= sd_q[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_q[k+1] <= 1'b0;
			end else if (en) begin
				vv_q[k+1] <= vv_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= 32'(32'(m00) * 32'(m00) + 32'(m01) * 32'(m01));
		end
	end
	assign rn_q[0] = {4'd0, sq_s1, 28'd0};
	assign rr_q[0] = '0;

	for (genvar i = 0; i < RS; i++) begin : g_rt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_q[i] >= rr_q[i] + BIT) begin
					rn_q[i+1] <= rn_q[i] - (rr_q[i] + BIT);
					rr_q[i+1] <= (rr_q[i] >> 1) + BIT;
				end else begin
					rn_q[i+1] <= rn_q[i];
					rr_q[i+1] <= rr_q[i] >> 1;
				end
			end
		end
	end

	// Inputs to the CORDICs: operands aligned to the root result at stage RS+1.
	cval_t ya, xa, yb, xb, yc, xc, yd, xd, ye, xe;
	assign ya = -cval_t'(c_q[RS+1]) <<< 14; assign xa =  cval_t'(d_q[RS+1]) <<< 14;
	assign yb =  cval_t'(c_q[RS+1]) <<< 14; assign xb = -cval_t'(d_q[RS+1]) <<< 14;
	assign yc = -cval_t'(b_q[RS+1]) <<< 14; assign xc =  cval_t'(a_q[RS+1]) <<< 14;
	assign yd =  cval_t'(b_q[RS+1]) <<< 14; assign xd = -cval_t'(a_q[RS+1]) <<< 14;
	assign ye =  cval_t'(sd_q[RS+1].m02) <<< 14;
	assign xe =  cval_t'(rr_q[RS][CW-2:0]);

	rxyz_atan2 #(.STEPS(STEPS), .AFB(AFB)) u_a (.clk, .en, .y(ya), .x(xa), .ang(x0));
	rxyz_atan2 #(.STEPS(STEPS), .AFB(AFB)) u_b (.clk, .en, .y(yb), .x(xb), .ang(x1));
	rxyz_atan2 #(.STEPS(STEPS), .AFB(AFB)) u_c (.clk, .en, .y(yc), .x(xc), .ang(z0));
	rxyz_atan2 #(.STEPS(STEPS), .AFB(AFB)) u_d (.clk, .en, .y(yd), .x(xd), .ang(z1));
	rxyz_atan2 #(.STEPS(STEPS), .AFB(AFB)) u_e (.clk, .en, .y(ye), .x(xe), .ang(y0));

	assign out_v    = vv_q[LAT];
	assign side_out = sd_q[LAT];

endmodule

// ===== hw/rtl/rxyz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxyz_back
// Pitch solution choice and roll/yaw unwrapping with saturation.
// ----------------------------------------------------------------------------
module rxyz_back import rxyz_pkg::*; #(
	parameter int AFB = 12
) (
	input  logic signed [AFB+5:0] x0,
	input  logic signed [AFB+5:0] x1,
	input  logic signed [AFB+5:0] z0,
	input  logic signed [AFB+5:0] z1,
	input  logic signed [AFB+5:0] y0,
	input  side_t                 side,
	output logic [49:0]           res
);
	localparam int SH = 30 - AFB;
	localparam longint PIA = longint'((PI_Q30 + (64'd1 << (SH - 1))) >> SH);
	localparam longint TPA = longint'((2 * PI_Q30 + (64'd1 << (SH - 1))) >> SH);
	localparam longint LMA = longint'((((3 * PI_Q30) >> 1) + (64'd1 << (SH - 1))) >> SH);
	typedef logic signed [AFB+9:0] w_t;

	function automatic logic signed [15:0] sat(input w_t v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic w_t unw(input w_t r, input w_t a);
		if (r - a > w_t'(LMA)) return a + w_t'(TPA);
		if (r - a < -w_t'(LMA)) return a - w_t'(TPA);
		return a;
	endfunction

	w_t wy0, wy1, rp, d0, d1, win, p, xr, zr;
	logic sel, miss;

	always_comb begin
		wy0 = w_t'(y0);
		wy1 = ((side.m02 > 0) ? w_t'(PIA) : -w_t'(PIA)) - wy0;
		rp  = w_t'(side.rp);
		win = w_t'({1'b0, side.win});
		d0  = rp - wy0;
		d1  = rp - wy1;
		sel = 1'b0; miss = 1'b0;
		if ((d0 < 0 ? -d0 : d0) < win) p = wy0;
		else if ((d1 < 0 ? -d1 : d1) < win) begin p = wy1; sel = 1'b1; end
		else if (d1 > w_t'(LMA)) begin p = wy1 + w_t'(TPA); sel = 1'b1; end
		else if (d1 < -w_t'(LMA)) begin p = wy1 - w_t'(TPA); sel = 1'b1; end
		else if (d0 > w_t'(LMA)) p = wy0 + w_t'(TPA);
		else if (d0 < -w_t'(LMA)) p = wy0 - w_t'(TPA);
		else begin p = wy0; miss = 1'b1; end
		xr = unw(w_t'(side.rr), sel ? w_t'(x1) : w_t'(x0));
		zr = unw(w_t'(side.ry), sel ? w_t'(z1) : w_t'(z0));
		res = {sat(xr), sat(p), sat(zr), sel, miss};
	end

endmodule

// ===== dv/rotation_to_xyz_euler_unwrap_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_to_xyz_euler_unwrap_core_tb
// Self-checking bench for the rotation matrix to Euler angle block.
// Matrix beats with reference angles are pushed under random gaps while the
// result side pops under random stalls; every popped beat is compared with an
// in-bench CORDIC and square root predictor across several pitch windows.
// ----------------------------------------------------------------------------
module rotation_to_xyz_euler_unwrap_core_tb;
	import rxyz_pkg::*;

	localparam longint PI_FIX_Q30 = 64'sd3373259426;
	localparam int     LIMIT      = 2000000;
	localparam longint ATAN_TAB [16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768
	};

	typedef struct {
		logic signed [15:0] m00, m01, m02, m12, m22, rr, rp, ry;
	} pose_t;

	typedef struct {
		logic signed [15:0] roll, pitch, yaw;
		logic               alt, miss;
	} euler_t;

	function automatic longint vec_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_FIX_Q30 : -PI_FIX_Q30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN_TAB[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_TAB[i];
			end
		end
		return (z + (64'sd1 <<< 17)) >>> 18;
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint shift_turn(longint r, longint a, longint tp, longint lim);
		if (r - a > lim)
			return a + tp;
		if (r - a < -lim)
			return a - tp;
		return a;
	endfunction

	function automatic euler_t euler_of(pose_t p, longint win);
		longint pi_a, tp, lim, s, y0, y1, pch, rp, d0, d1;
		longint xs [2], zs [2];
		int sel, miss;
		euler_t e;
		pi_a = (PI_FIX_Q30 + (64'sd1 <<< 17)) >>> 18;
		tp   = (2 * PI_FIX_Q30 + (64'sd1 <<< 17)) >>> 18;
		lim  = (((3 * PI_FIX_Q30) >>> 1) + (64'sd1 <<< 17)) >>> 18;
		s = root_floor(longint'(longint'(p.m00) * p.m00 + longint'(p.m01) * p.m01) << 28);
		xs[0] = vec_angle(-longint'(p.m12) * 16384, longint'(p.m22) * 16384);
		xs[1] = vec_angle(longint'(p.m12) * 16384, -longint'(p.m22) * 16384);
		zs[0] = vec_angle(-longint'(p.m01) * 16384, longint'(p.m00) * 16384);
		zs[1] = vec_angle(longint'(p.m01) * 16384, -longint'(p.m00) * 16384);
		y0 = vec_angle(longint'(p.m02) * 16384, s);
		y1 = (p.m02 > 0 ? pi_a : -pi_a) - y0;
		rp = longint'(p.rp);
		d0 = rp - y0;
		d1 = rp - y1;
		sel = 0;
		miss = 0;
		if ((d0 < 0 ? -d0 : d0) < win) begin
			pch = y0;
		end else if ((d1 < 0 ? -d1 : d1) < win) begin
			pch = y1;
			sel = 1;
		end else if (d1 > lim) begin
			pch = y1 + tp;
			sel = 1;
		end else if (d1 < -lim) begin
			pch = y1 - tp;
			sel = 1;
		end else if (d0 > lim) begin
			pch = y0 + tp;
		end else if (d0 < -lim) begin
			pch = y0 - tp;
		end else begin
			pch = y0;
			miss = 1;
		end
		e.roll  = clip16(shift_turn(longint'(p.rr), xs[sel], tp, lim));
		e.pitch = clip16(pch);
		e.yaw   = clip16(shift_turn(longint'(p.ry), zs[sel], tp, lim));
		e.alt   = sel[0];
		e.miss  = miss[0];
		return e;
	endfunction

	class euler_board;
		euler_t pending [$];
		int errors, seen, alt_seen, miss_seen;

		function void note(euler_t e);
			pending = {pending, e};
		endfunction

		function void check(euler_t got);
			euler_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat roll %0d pitch %0d yaw %0d",
					$time, got.roll, got.pitch, got.yaw);
				errors++;
				return;
			end
			want = pending.pop_front();
			seen++;
			alt_seen += int'(want.alt);
			miss_seen += int'(want.miss);
			if (got.roll !== want.roll) begin
				$display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
				errors++;
			end
			if (got.pitch !== want.pitch) begin
				$display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
				errors++;
			end
			if (got.yaw !== want.yaw) begin
				$display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
				errors++;
			end
			if (got.alt !== want.alt) begin
				$display("%0t: second_solution expected %0b actual %0b",
					$time, want.alt, got.alt);
				errors++;
			end
			if (got.miss !== want.miss) begin
				$display("%0t: no_pitch_match expected %0b actual %0b",
					$time, want.miss, got.miss);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic cfg_valid = 0;
	logic [13:0] cfg_data = '0;
	logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m12 = 0, m22 = 0;
	logic signed [15:0] ref_roll = 0, ref_pitch = 0, ref_yaw = 0;
	logic full, empty, cfg_ready, second_solution, no_pitch_match;
	logic signed [15:0] roll_out, pitch_out, yaw_out;

	euler_board board = new();
	longint window_now = 6431;
	bit steady = 0;
	bit hold_req = 0;
	int cycles = 0;
	int pushed = 0;

	always #5 clk = ~clk;

	rotation_to_xyz_euler_unwrap_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.m00(m00), .m01(m01), .m02(m02), .m12(m12), .m22(m22),
		.ref_roll(ref_roll), .ref_pitch(ref_pitch), .ref_yaw(ref_yaw),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .roll_out(roll_out), .pitch_out(pitch_out),
		.yaw_out(yaw_out), .second_solution(second_solution),
		.no_pitch_match(no_pitch_match)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: pops at random, or always in the steady phase, with one long hold-off on request.
	initial begin
		euler_t got;
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.roll  = roll_out;
				got.pitch = pitch_out;
				got.yaw   = yaw_out;
				got.alt   = second_solution;
				got.miss  = no_pitch_match;
				board.check(got);
			end
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				pop = 0;
			end else if (steady) begin
				pop = 1;
			end else begin
				pop = (gap_len() == 0);
			end
		end
	end

	task automatic send_pose(pose_t p);
		@(negedge clk);
		m00 = p.m00;
		m01 = p.m01;
		m02 = p.m02;
		m12 = p.m12;
		m22 = p.m22;
		ref_roll = p.rr;
		ref_pitch = p.rp;
		ref_yaw = p.ry;
		push = 1;
		do @(posedge clk); while (full);
		board.note(euler_of(p, window_now));
		pushed++;
	endtask

	task automatic idle_after();
		int g;
		g = steady ? 0 : gap_len();
		if (g > 0) begin
			@(negedge clk);
			push = 0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain_and_set(logic [13:0] w);
		@(negedge clk);
		push = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_data = w;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		window_now = longint'(w);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic logic signed [15:0] elem();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return -16'sd16384;
		if (r == 1)
			return 16'sd16384;
		if (r == 2)
			return '0;
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic logic signed [15:0] angle();
		if ($urandom_range(0, 2) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		real a, b, c;
		if ($urandom_range(0, 3) != 0) begin
			// Proper rotation matrix built from random angles.
			a = ($urandom_range(0, 62831) - 31415) / 10000.0;
			b = ($urandom_range(0, 62831) - 31415) / 10000.0;
			c = ($urandom_range(0, 62831) - 31415) / 10000.0;
			p.m00 = 16'($rtoi(16384.0 * $cos(b) * $cos(c)));
			p.m01 = 16'($rtoi(-16384.0 * $cos(b) * $sin(c)));
			p.m02 = 16'($rtoi(16384.0 * $sin(b)));
			p.m12 = 16'($rtoi(-16384.0 * $sin(a) * $cos(b)));
			p.m22 = 16'($rtoi(16384.0 * $cos(a) * $cos(b)));
		end else begin
			p.m00 = elem();
			p.m01 = elem();
			p.m02 = elem();
			p.m12 = elem();
			p.m22 = elem();
		end
		p.rr = angle();
		p.rp = angle();
		p.ry = angle();
		return p;
	endfunction

	function automatic pose_t mk(int a, int b, int c, int d, int e, int x, int y, int z);
		pose_t p;
		p.m00 = 16'(a); p.m01 = 16'(b); p.m02 = 16'(c); p.m12 = 16'(d); p.m22 = 16'(e);
		p.rr = 16'(x); p.rp = 16'(y); p.ry = 16'(z);
		return p;
	endfunction

	initial begin
		pose_t dir [$];
		logic [13:0] windows [5];
		windows = '{14'd0, 14'd12868, 14'd16383, 14'd6431, 14'd1000};
		dir = '{
			mk(16384, 0, 0, 0, 16384, 0, 0, 0),
			mk(0, 0, 0, 0, 0, 0, 0, 0),
			mk(-16384, 0, 0, 0, -16384, 0, 0, 0),
			mk(0, 0, 16384, 0, 0, 0, 6434, 0),
			mk(0, 0, -16384, 0, 0, 0, -6434, 0),
			mk(0, 16384, 16384, -16384, 0, 32767, 32767, 32767),
			mk(0, -16384, -16384, 16384, 0, -32768, -32768, -32768),
			mk(16384, 16384, 16384, 16384, 16384, 32767, -32768, 32767),
			mk(-16384, -16384, -16384, -16384, -16384, -32768, 32767, -32768),
			mk(11585, -11585, 0, 11585, 11585, 0, 12868, 0),
			mk(11585, 11585, 8192, -8192, 11585, 25000, -25000, -25000),
			mk(-11585, 0, 8192, 0, -16384, 0, 4000, 0),
			mk(16384, 0, 0, 0, 16384, 32767, 32767, -32768),
			mk(-16384, 0, 0, 0, -16384, -32768, -32768, 32767),
			mk(0, 0, 16384, 0, 0, 0, 15000, 0),
			mk(0, 0, -16384, 0, 0, 0, -15000, 0),
			mk(16384, 0, 100, 0, 16384, 0, 12868, 0),
			mk(16384, 0, -100, 0, 16384, 0, -12868, 0),
			mk(-1, 1, -1, 1, -1, 1, -1, 1),
			mk(1, -1, 1, -1, 1, -1, 1, -1)
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (dir[i]) begin
			send_pose(dir[i]);
			idle_after();
		end
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_set(windows[ph]);
			steady = (ph == 3);
			for (int k = 0; k < 326; k++) begin
				if (ph == 1 && k == 20)
					hold_req = 1;
				send_pose(rand_pose());
				idle_after();
			end
		end
		@(negedge clk);
		push = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d poses pushed, %0d results checked over five pitch windows",
			pushed, board.seen);
		$display("%0d took the second solution, %0d had no pitch match",
			board.alt_seen, board.miss_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rxyz_pkg.sv
hw/rtl/rxyz_atan2.sv
hw/rtl/rxyz_front.sv
hw/rtl/rxyz_back.sv
hw/rtl/rotation_to_xyz_euler_unwrap_core.sv
dv/rotation_to_xyz_euler_unwrap_core_tb.sv
